// ----- hw/rtl/skp_pkg.sv -----
package skp_pkg;

  // Defaults for the top level parameters
  localparam int unsigned MaxNodesDef = 64;
  localparam int unsigned MaxDimDef   = 4096;

  // Area and padding constants
  localparam int unsigned MinDim = 128;
  localparam int unsigned Pad    = 2;
  localparam int unsigned Ofs    = 1;

  // Register reset values
  localparam logic [12:0] RstInitW   = 13'd512;
  localparam logic [12:0] RstInitH   = 13'd512;
  localparam logic [6:0]  RstRsvRows = 7'd12;

  // Register indexes on the configuration port
  typedef enum logic [1:0] {
    RegInitW   = 2'd0,
    RegInitH   = 2'd1,
    RegRsvRows = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [12:0] init_w;
    logic [12:0] init_h;
    logic [6:0]  rsv_rows;
  } cfg_t;

  // Padded request as queued between front and engine
  typedef struct packed {
    logic [12:0] w;
    logic [12:0] h;
  } req_t;

  typedef struct packed {
    logic        placed;
    logic [11:0] pos_x;
    logic [11:0] pos_y;
    logic [12:0] area_w;
    logic [12:0] area_h;
  } res_t;

  typedef enum logic [3:0] {
    StIdle,
    StChkW,
    StGrowW,
    StChkH,
    StGrowH,
    StScanI,
    StScanX,
    StScanJ,
    StScanW,
    StRbRd,
    StRbNode,
    StRbTail,
    StRbFlush,
    StDone
  } eng_st_e;

endpackage

// ----- hw/rtl/skyline_rect_packer.sv -----
// Skyline rectangle packer: each request is padded by two on both axes and placed
// bottom-left on a skyline of up to MAX_NODES nodes, growing the area by doubling
// up to MAX_DIM; one result per request, placed low on failure. A two-entry
// request queue takes items while the engine works. One scan pass reads one node
// a cycle from the single read port of the node memory. A pass that finds no fit
// doubles the height and scans again. A placement or a width growth rebuilds the
// table into the other memory bank, and an oversize request grows the area by
// repeated doubling. Writing any register restarts the area empty.
module skyline_rect_packer #(
  parameter int unsigned MAX_NODES = skp_pkg::MaxNodesDef,
  parameter int unsigned MAX_DIM   = skp_pkg::MaxDimDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        req_valid_i,
  output logic        req_ready_o,
  input  logic [11:0] req_width_i,
  input  logic [11:0] req_height_i,
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output logic        placed_o,
  output logic [11:0] pos_x_o,
  output logic [11:0] pos_y_o,
  output logic [12:0] area_width_o,
  output logic [12:0] area_height_o
);
  import skp_pkg::*;

  cfg_t cfg_q;
  logic init_q;
  logic wr;
  logic q_valid;
  logic q_pop;
  req_t q_req;
  res_t res;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  // Write registers and flag a restart of the area
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.init_w   <= RstInitW;
      cfg_q.init_h   <= RstInitH;
      cfg_q.rsv_rows <= RstRsvRows;
      init_q         <= 1'b0;
    end else begin
      init_q <= 1'b0;
      if (wr) begin
        unique case (reg_idx_e'(paddr[3:2]))
          RegInitW: begin
            cfg_q.init_w <= pwdata[12:0];
            init_q       <= 1'b1;
          end
          RegInitH: begin
            cfg_q.init_h <= pwdata[12:0];
            init_q       <= 1'b1;
          end
          RegRsvRows: begin
            cfg_q.rsv_rows <= pwdata[6:0];
            init_q         <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  // Read back registers
  always_comb begin
    unique case (reg_idx_e'(paddr[3:2]))
      RegInitW:   prdata = 32'(cfg_q.init_w);
      RegInitH:   prdata = 32'(cfg_q.init_h);
      RegRsvRows: prdata = 32'(cfg_q.rsv_rows);
      default:    prdata = '0;
    endcase
  end

  skp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_valid_i),
    .req_ready_o  (req_ready_o),
    .req_width_i  (req_width_i),
    .req_height_i (req_height_i),
    .q_valid_o    (q_valid),
    .q_req_o      (q_req),
    .q_pop_i      (q_pop)
  );

  skp_engine #(
    .MAX_NODES (MAX_NODES),
    .MAX_DIM   (MAX_DIM)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .init_i      (init_q),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_req_i     (q_req),
    .q_pop_o     (q_pop),
    .res_valid_o (res_valid_o),
    .res_ready_i (res_ready_i),
    .res_o       (res)
  );

  assign placed_o      = res.placed;
  assign pos_x_o       = res.pos_x;
  assign pos_y_o       = res.pos_y;
  assign area_width_o  = res.area_w;
  assign area_height_o = res.area_h;

endmodule

// ----- hw/rtl/skp_ram.sv -----
module skp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write one entry, read one entry with registered data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/skp_front.sv -----
module skp_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  input  logic [11:0]   req_width_i,
  input  logic [11:0]   req_height_i,
  output logic          q_valid_o,
  output skp_pkg::req_t q_req_o,
  input  logic          q_pop_i
);
  import skp_pkg::*;

  req_t       slot_q [2];
  logic [1:0] fill_q;
  logic       wp_q;
  logic       rp_q;
  logic       push;
  logic       pop;
  req_t       padded;

  // Pad each side before queueing
  always_comb begin
    padded.w = 13'(req_width_i) + 13'(Pad);
    padded.h = 13'(req_height_i) + 13'(Pad);
  end

  assign req_ready_o = (fill_q != 2'd2);
  assign push        = req_valid_i && req_ready_o;
  assign pop         = q_pop_i && (fill_q != 2'd0);
  assign q_valid_o   = (fill_q != 2'd0);
  assign q_req_o     = slot_q[rp_q];

  // Advance queue pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= 2'd0;
      wp_q   <= 1'b0;
      rp_q   <= 1'b0;
    end else begin
      if (push) begin
        wp_q <= ~wp_q;
      end
      if (pop) begin
        rp_q <= ~rp_q;
      end
      if (push && !pop) begin
        fill_q <= fill_q + 2'd1;
      end else if (pop && !push) begin
        fill_q <= fill_q - 2'd1;
      end
    end
  end

  // Hold queued items
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wp_q] <= padded;
    end
  end

endmodule

// ----- hw/rtl/skp_engine.sv -----
module skp_engine #(
  parameter int unsigned MAX_NODES = skp_pkg::MaxNodesDef,
  parameter int unsigned MAX_DIM   = skp_pkg::MaxDimDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          init_i,
  input  skp_pkg::cfg_t cfg_i,
  input  logic          q_valid_i,
  input  skp_pkg::req_t q_req_i,
  output logic          q_pop_o,
  output logic          res_valid_o,
  input  logic          res_ready_i,
  output skp_pkg::res_t res_o
);
  import skp_pkg::*;

  localparam int unsigned IW  = $clog2(MAX_NODES);
  localparam int unsigned CW  = $clog2(MAX_NODES + 1);
  localparam int unsigned DW  = ($clog2(MAX_DIM) + 2 > 14) ? $clog2(MAX_DIM) + 2 : 14;
  localparam int unsigned WW  = 2 * DW;
  localparam int unsigned NDW = 3 * DW;
  localparam logic [DW-1:0] MaxD  = DW'(MAX_DIM);
  localparam logic [CW-1:0] NMax  = CW'(MAX_NODES);
  localparam logic [DW-1:0] PadD  = DW'(Pad);
  localparam logic [DW-1:0] OneD  = DW'(Ofs);

  function automatic logic [DW-1:0] clamp_dim(input logic [13:0] v);
    logic [DW-1:0] r;
    if (32'(v) < MinDim) begin
      r = DW'(MinDim);
    end else if (32'(v) > MAX_DIM) begin
      r = MaxD;
    end else begin
      r = DW'(v);
    end
    return r;
  endfunction

  function automatic logic [DW-1:0] start_h(input logic [12:0] ih, input logic [6:0] rr);
    logic [13:0] lo;
    logic [13:0] hh;
    lo = 14'(rr) + 14'd2;
    hh = (14'(ih) < lo) ? lo : 14'(ih);
    return clamp_dim(hh);
  endfunction

  eng_st_e state_q, state_d;

  logic [DW-1:0] cur_w_q, cur_h_q, w_q, h_q, dim_q;
  logic [CW-1:0] cnt_q, i_q;
  logic          init_q, bank_q, rd_zero_q;
  logic [IW-1:0] j_q, bi_q, k_q, o_q;
  logic [DW-1:0] xi_q, y_q, rem_q, bx_q, by_q, btop_q;
  logic [WW-1:0] s_q, bw_q;
  logic          found_q, app_q, ins_done_q, ok_q;
  logic [DW-1:0] p_x_q, p_top_q, p_span_q;
  logic          p_vld_q;
  logic [11:0]   px_q, py_q;
  res_t          res_q;
  logic          res_vld_q;

  // Memory ports
  logic [NDW-1:0] rd0, rd1, rdw, wdata;
  logic [IW-1:0]  raddr;
  logic           we;

  // Node read from the current bank
  logic [DW-1:0] nd_x, nd_top, nd_span;

  // Push into the merge stage of a rebuild
  logic          push_en, merge;
  logic [DW-1:0] push_x, push_top, push_span;

  // Shared datapath terms
  logic          w_big, h_big, gw_more, gh_more, dim_over, tbl_full, scan_done;
  logic          x_miss, y_miss, j_last, better, ins_here, k_last;
  logic [DW-1:0] h_dbl, ny, used, rem_nx, cand_top, right, over;
  logic [WW-1:0] cand_waste;

  skp_ram #(.Width(NDW), .Depth(MAX_NODES)) u_bank0 (
    .clk_i   (clk_i),
    .we_i    (we && bank_q),
    .waddr_i (o_q),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rd0)
  );

  skp_ram #(.Width(NDW), .Depth(MAX_NODES)) u_bank1 (
    .clk_i   (clk_i),
    .we_i    (we && !bank_q),
    .waddr_i (o_q),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rd1)
  );

  // Select bank; entry zero reads as the initial node until first rebuild
  always_comb begin
    rdw     = bank_q ? rd1 : rd0;
    nd_x    = rdw[NDW-1:2*DW];
    nd_top  = rdw[2*DW-1:DW];
    nd_span = rdw[DW-1:0];
    if (init_q && rd_zero_q) begin
      nd_x    = OneD;
      nd_top  = DW'(cfg_i.rsv_rows);
      nd_span = cur_w_q - PadD;
    end
  end

  // Compare, fit and cost terms
  always_comb begin
    w_big      = w_q > cur_w_q - PadD;
    h_big      = h_q > cur_h_q - PadD;
    gw_more    = (dim_q < w_q + PadD) && (dim_q <= MaxD);
    gh_more    = (dim_q < h_q + PadD) && (dim_q <= MaxD);
    dim_over   = dim_q > MaxD;
    tbl_full   = cnt_q >= NMax;
    scan_done  = i_q == cnt_q;
    h_dbl      = cur_h_q << 1;
    x_miss     = nd_x + w_q > cur_w_q - OneD;
    ny         = (nd_top > y_q) ? nd_top : y_q;
    y_miss     = ny + h_q > cur_h_q - OneD;
    used       = (rem_q < nd_span) ? rem_q : nd_span;
    rem_nx     = rem_q - used;
    j_last     = (CW'(j_q) + CW'(1)) >= cnt_q;
    cand_waste = WW'(y_q) * WW'(w_q) - s_q;
    cand_top   = y_q + h_q;
    better     = !found_q || (cand_top < btop_q) ||
                 ((cand_top == btop_q) && (cand_waste < bw_q)) ||
                 ((cand_top == btop_q) && (cand_waste == bw_q) && (xi_q < bx_q));
    ins_here   = !app_q && !ins_done_q && (k_q == bi_q);
    k_last     = (CW'(k_q) + CW'(1)) >= cnt_q;
    right      = bx_q + w_q;
    over       = right - nd_x;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (q_valid_i && !res_vld_q) state_d = StChkW;
      end
      StChkW:  state_d = w_big ? StGrowW : StChkH;
      StGrowW: begin
        if (gw_more) state_d = StGrowW;
        else if (dim_over || tbl_full) state_d = StDone;
        else state_d = StRbRd;
      end
      StChkH:  state_d = h_big ? StGrowH : StScanI;
      StGrowH: begin
        if (gh_more) state_d = StGrowH;
        else if (dim_over) state_d = StDone;
        else state_d = StScanI;
      end
      StScanI: begin
        if (scan_done) begin
          if (found_q) state_d = tbl_full ? StDone : StRbRd;
          else state_d = (h_dbl > MaxD) ? StDone : StChkW;
        end else begin
          state_d = StScanX;
        end
      end
      StScanX: state_d = x_miss ? StScanI : StScanJ;
      StScanJ: begin
        if (y_miss) state_d = StScanI;
        else if (rem_nx == '0) state_d = StScanW;
        else if (j_last) state_d = StScanI;
        else state_d = StScanJ;
      end
      StScanW:  state_d = StScanI;
      StRbRd:   state_d = StRbNode;
      StRbNode: state_d = (!ins_here && k_last) ? StRbTail : StRbNode;
      StRbTail: state_d = StRbFlush;
      StRbFlush: state_d = app_q ? StChkH : StDone;
      StDone:   state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  // Read address, merge-stage push and writes
  always_comb begin
    raddr     = '0;
    push_en   = 1'b0;
    push_x    = nd_x;
    push_top  = nd_top;
    push_span = nd_span;
    q_pop_o   = 1'b0;
    unique case (state_q)
      StIdle:  q_pop_o = q_valid_i && !res_vld_q;
      StScanI: raddr = i_q[IW-1:0];
      StScanX: raddr = i_q[IW-1:0];
      StScanJ: raddr = j_q + IW'(1);
      StRbRd:  raddr = '0;
      StRbNode: begin
        raddr = ins_here ? k_q : k_q + IW'(1);
        if (ins_here) begin
          push_en   = 1'b1;
          push_x    = bx_q;
          push_top  = by_q + h_q;
          push_span = w_q;
        end else if (!app_q && ins_done_q && (nd_x < right)) begin
          // Trim the covered part, drop a node covered whole
          push_en   = over < nd_span;
          push_x    = nd_x + over;
          push_span = nd_span - over;
        end else begin
          push_en = 1'b1;
        end
      end
      StRbTail: begin
        push_en   = app_q;
        push_x    = cur_w_q - OneD;
        push_top  = DW'(cfg_i.rsv_rows);
        push_span = dim_q - cur_w_q;
      end
      default: raddr = '0;
    endcase
    merge = p_vld_q && (push_top == p_top_q) && (p_x_q + p_span_q == push_x);
    we    = (push_en && !merge && p_vld_q) || (state_q == StRbFlush);
    wdata = {p_x_q, p_top_q, p_span_q};
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      cur_w_q   <= clamp_dim(14'(RstInitW));
      cur_h_q   <= start_h(RstInitH, RstRsvRows);
      cnt_q     <= CW'(1);
      init_q    <= 1'b1;
      bank_q    <= 1'b0;
      res_vld_q <= 1'b0;
      rd_zero_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_zero_q <= (raddr == '0);
      if (init_i) begin
        cur_w_q <= clamp_dim(14'(cfg_i.init_w));
        cur_h_q <= start_h(cfg_i.init_h, cfg_i.rsv_rows);
        cnt_q   <= CW'(1);
        init_q  <= 1'b1;
      end
      if (state_q == StGrowH && !gh_more && !dim_over) cur_h_q <= dim_q;
      if (state_q == StScanI && scan_done && !found_q && !(h_dbl > MaxD)) begin
        cur_h_q <= h_dbl;
      end
      if (state_q == StRbFlush) begin
        bank_q <= ~bank_q;
        cnt_q  <= CW'(o_q) + CW'(1);
        init_q <= 1'b0;
        if (app_q) cur_w_q <= dim_q;
      end
      if (state_q == StDone) begin
        res_vld_q <= 1'b1;
      end else if (res_vld_q && res_ready_i) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        w_q  <= DW'(q_req_i.w);
        h_q  <= DW'(q_req_i.h);
        ok_q <= 1'b0;
        px_q <= '0;
        py_q <= '0;
      end
      StChkW:  dim_q <= cur_w_q;
      StGrowW: begin
        if (gw_more) dim_q <= dim_q << 1;
        app_q <= 1'b1;
      end
      StChkH: begin
        dim_q   <= cur_h_q;
        i_q     <= '0;
        found_q <= 1'b0;
      end
      StGrowH: begin
        if (gh_more) dim_q <= dim_q << 1;
        i_q     <= '0;
        found_q <= 1'b0;
      end
      StScanI: app_q <= 1'b0;
      StScanX: begin
        xi_q  <= nd_x;
        j_q   <= i_q[IW-1:0];
        y_q   <= '0;
        rem_q <= w_q;
        s_q   <= '0;
        if (x_miss) i_q <= i_q + CW'(1);
      end
      StScanJ: begin
        y_q   <= ny;
        rem_q <= rem_nx;
        s_q   <= s_q + WW'(nd_top) * WW'(used);
        j_q   <= j_q + IW'(1);
        if (y_miss || (rem_nx != '0 && j_last)) i_q <= i_q + CW'(1);
      end
      StScanW: begin
        if (better) begin
          found_q <= 1'b1;
          bi_q    <= i_q[IW-1:0];
          bx_q    <= xi_q;
          by_q    <= y_q;
          btop_q  <= cand_top;
          bw_q    <= cand_waste;
        end
        i_q <= i_q + CW'(1);
      end
      StRbRd: begin
        k_q        <= '0;
        o_q        <= '0;
        p_vld_q    <= 1'b0;
        ins_done_q <= 1'b0;
      end
      StRbNode: begin
        if (ins_here) ins_done_q <= 1'b1;
        else k_q <= k_q + IW'(1);
      end
      StRbFlush: begin
        if (!app_q) begin
          ok_q <= 1'b1;
          px_q <= 12'(bx_q + OneD);
          py_q <= 12'(by_q + OneD);
        end
      end
      StDone: begin
        res_q.placed <= ok_q;
        res_q.pos_x  <= px_q;
        res_q.pos_y  <= py_q;
        res_q.area_w <= 13'(cur_w_q);
        res_q.area_h <= 13'(cur_h_q);
      end
      default: ;
    endcase
    // Merge equal neighbors as nodes stream into the other bank
    if (push_en) begin
      if (merge) begin
        p_span_q <= p_span_q + push_span;
      end else begin
        if (p_vld_q) o_q <= o_q + IW'(1);
        p_x_q    <= push_x;
        p_top_q  <= push_top;
        p_span_q <= push_span;
        p_vld_q  <= 1'b1;
      end
    end
  end

  assign res_valid_o = res_vld_q;
  assign res_o       = res_q;

endmodule
